FILE: rtl/usd_pkg.sv
package usd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 26;
   localparam int unsigned LEN_W  = 3;
   localparam int unsigned CNT_W  = 3;

   localparam logic [CP_W-1:0]   REPLACEMENT_CHAR = CP_W'(32'h0000_FFFD);
   localparam logic [BYTE_W-1:0] CONT_FIRST       = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_FIRST       = 8'hC0;

   // lead prefixes, compared against the upper bits of the byte
   localparam logic [2:0] PREFIX_LEN2 = 3'b110;
   localparam logic [3:0] PREFIX_LEN3 = 4'b1110;
   localparam logic [4:0] PREFIX_LEN4 = 5'b11110;
   localparam logic [5:0] PREFIX_LEN5 = 6'b111110;

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;
   localparam logic [LEN_W-1:0] LEN_FIVE  = 3'd5;

   typedef struct packed {
      logic              valid;
      logic [CP_W-1:0]   code_point;
      logic [LEN_W-1:0]  seq_length;
      logic              stray_continuation;
   } usd_result_type;

   typedef struct packed {
      logic [CNT_W-1:0]  pending_count;
      logic [LEN_W-1:0]  current_length;
   } usd_status_type;

endpackage

FILE: rtl/usd_core.sv
module usd_core
   import usd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [BYTE_W-1:0]   data_byte,
   output usd_result_type      result,
   output usd_status_type      status
);

   logic [CNT_W-1:0] pending_count_ff, pending_count_in;
   logic [CP_W-1:0]  partial_value_ff, partial_value_in;
   logic [LEN_W-1:0] current_length_ff, current_length_in;

   logic [CP_W-1:0]  shifted;
   logic [CNT_W-1:0] count_dec;

   assign shifted   = {partial_value_ff[CP_W-7:0], data_byte[5:0]};
   assign count_dec = pending_count_ff - CNT_W'(1);

   always_comb begin
      pending_count_in          = pending_count_ff;
      partial_value_in          = partial_value_ff;
      current_length_in         = current_length_ff;
      result.valid              = 1'b0;
      result.code_point         = '0;
      result.seq_length         = LEN_ONE;
      result.stray_continuation = 1'b0;

      if (pending_count_ff != '0) begin
         // inside an open sequence every byte is continuation payload
         pending_count_in = count_dec;
         if (count_dec == '0) begin
            result.valid      = 1'b1;
            result.code_point = shifted;
            result.seq_length = current_length_ff;
            partial_value_in  = '0;
            current_length_in = '0;
         end else begin
            partial_value_in = shifted;
         end
      end else if (data_byte < CONT_FIRST) begin
         result.valid      = 1'b1;
         result.code_point = CP_W'(data_byte);
      end else if (data_byte < LEAD_FIRST) begin
         result.valid              = 1'b1;
         result.code_point         = REPLACEMENT_CHAR;
         result.stray_continuation = 1'b1;
      end else if (data_byte[7:5] == PREFIX_LEN2) begin
         partial_value_in  = CP_W'(data_byte[4:0]);
         pending_count_in  = CNT_W'(1);
         current_length_in = LEN_TWO;
      end else if (data_byte[7:4] == PREFIX_LEN3) begin
         partial_value_in  = CP_W'(data_byte[3:0]);
         pending_count_in  = CNT_W'(2);
         current_length_in = LEN_THREE;
      end else if (data_byte[7:3] == PREFIX_LEN4) begin
         partial_value_in  = CP_W'(data_byte[2:0]);
         pending_count_in  = CNT_W'(3);
         current_length_in = LEN_FOUR;
      end else if (data_byte[7:2] == PREFIX_LEN5) begin
         partial_value_in  = CP_W'(data_byte[1:0]);
         pending_count_in  = CNT_W'(4);
         current_length_in = LEN_FIVE;
      end else begin
         // 0xFC..0xFF: no prefix, emit low six bits
         result.valid      = 1'b1;
         result.code_point = CP_W'(data_byte[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_count_ff  <= '0;
         partial_value_ff  <= '0;
         current_length_ff <= '0;
      end else if (step) begin
         pending_count_ff  <= pending_count_in;
         partial_value_ff  <= partial_value_in;
         current_length_ff <= current_length_in;
      end
   end

   assign status.pending_count  = pending_count_ff;
   assign status.current_length = current_length_ff;

endmodule

FILE: rtl/utf8_stream_decoder.sv
// A req byte lands in the input register, then passes through usd_core into the result
// register, which drives rsp_valid, once that register is empty or being drained.
// Throughput: one byte per cycle unless rsp stalls; decode is one pass through usd_core.
// A byte that only extends an open sequence produces no rsp transaction.
// Reset (synchronous, active high) empties both registers and clears the decoder
// state; a sequence still open at reset is dropped.
module utf8_stream_decoder
   import usd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CP_W-1:0]     rsp_code_point,
   output logic [LEN_W-1:0]    rsp_seq_length,
   output logic                rsp_stray_continuation
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [CP_W-1:0]   out_cp_ff, out_cp_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic              out_stray_ff, out_stray_in;

   usd_result_type    result;
   usd_status_type    status;
   logic              advance;
   logic              req_fire;

   // The byte in the input register advances through the decoder whenever the
   // result register is empty or is being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   usd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (result),
      .status    (status)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cp_in    = out_cp_ff;
      out_len_in   = out_len_ff;
      out_stray_in = out_stray_ff;
      if (advance) begin
         // load the result, or go empty when the byte only extends a sequence
         out_valid_in = result.valid;
         out_cp_in    = result.code_point;
         out_len_in   = result.seq_length;
         out_stray_in = result.stray_continuation;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_cp_ff    <= out_cp_in;
      out_len_ff   <= out_len_in;
      out_stray_ff <= out_stray_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_code_point         = out_cp_ff;
   assign rsp_seq_length         = out_len_ff;
   assign rsp_stray_continuation = out_stray_ff;

   // a stray continuation always carries the replacement character, length one
   a_stray_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stray_continuation |->
         rsp_code_point == REPLACEMENT_CHAR && rsp_seq_length == LEN_ONE)
      else $error("stray continuation result malformed");

   // no more than four continuation bytes are ever expected
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      status.pending_count <= CNT_W'(4))
      else $error("pending count out of range");

   // a new result appears only after a byte moved through the decoder
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("result appeared without a decoded byte");

   // an open sequence is at least two long and longer than the bytes still expected
   a_open_length: assert property (@(posedge clock) disable iff (reset)
      status.pending_count != '0 |->
         status.current_length > LEN_W'(status.pending_count)
         && status.current_length >= LEN_TWO)
      else $error("open sequence length inconsistent");

endmodule

FILE: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import usd_pkg::*;

   // One decoded character as it should leave the rsp channel.
   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             stray;
   } decoded_char_type;

   // Scoreboard: mirrors the decoder state, queues the characters that each
   // accepted byte completes and checks every rsp transaction against them.
   class char_board_type;
      decoded_char_type expected_chars[$];
      logic [CNT_W-1:0] bytes_owed;
      logic [CP_W-1:0]  gathered_bits;
      logic [LEN_W-1:0] open_len;
      int               errors;

      function new();
         bytes_owed    = '0;
         gathered_bits = '0;
         open_len      = '0;
         errors        = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function logic [LEN_W-1:0] lead_len(logic [BYTE_W-1:0] b);
         if (b[7:5] == PREFIX_LEN2) return LEN_TWO;
         if (b[7:4] == PREFIX_LEN3) return LEN_THREE;
         if (b[7:3] == PREFIX_LEN4) return LEN_FOUR;
         if (b[7:2] == PREFIX_LEN5) return LEN_FIVE;
         return LEN_ONE;
      endfunction

      function void queue_char(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len, logic stray);
         decoded_char_type c;
         c.code_point = cp;
         c.seq_length = len;
         c.stray      = stray;
         expected_chars.insert(expected_chars.size(), c);
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         logic [LEN_W-1:0] len;
         if (bytes_owed != '0) begin
            // inside an open sequence every byte is payload, whatever its prefix
            gathered_bits = {gathered_bits[CP_W-7:0], b[5:0]};
            bytes_owed    = bytes_owed - 1'b1;
            if (bytes_owed == '0) begin
               queue_char(gathered_bits, open_len, 1'b0);
               gathered_bits = '0;
               open_len      = '0;
            end
         end else if (b < CONT_FIRST) begin
            queue_char(CP_W'(b), LEN_ONE, 1'b0);
         end else if (b < LEAD_FIRST) begin
            queue_char(REPLACEMENT_CHAR, LEN_ONE, 1'b1);
         end else begin
            len = lead_len(b);
            if (len == LEN_ONE) begin
               queue_char(CP_W'(b[5:0]), LEN_ONE, 1'b0);
            end else begin
               gathered_bits = CP_W'(b & (8'hFF >> (len + 1)));
               bytes_owed    = CNT_W'(len - 1'b1);
               open_len      = len;
            end
         end
      endfunction

      task check_char(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len, logic stray);
         decoded_char_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%h len=%0d stray=%b",
                                      cp, len, stray));
            return;
         end
         want = expected_chars.pop_front();
         if (cp !== want.code_point)
            report_mismatch($sformatf("code_point %h, want %h", cp, want.code_point));
         if (len !== want.seq_length)
            report_mismatch($sformatf("seq_length %0d, want %0d", len, want.seq_length));
         if (stray !== want.stray)
            report_mismatch($sformatf("stray_continuation %b, want %b", stray, want.stray));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic [LEN_W-1:0]  rsp_seq_length;
   logic              rsp_stray_continuation;

   // idle_on enables random gaps on both sides; pressure_go requests one long
   // receiver hold-off. Both change only at the falling edge, nonblocking.
   logic              idle_on = 1'b0;
   logic              pressure_go = 1'b0;

   char_board_type    sb;

   utf8_stream_decoder dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_code_point         (rsp_code_point),
      .rsp_seq_length         (rsp_seq_length),
      .rsp_stray_continuation (rsp_stray_continuation)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: far above the slowest legal run (max gaps and stalls on
   // every byte plus the long hold-off).
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Monitor: sample both channels at the rising edge. Feed each accepted
   // byte to the predictor and check each accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_byte(req_data_byte);
         if (rsp_valid && rsp_ready)
            sb.check_char(rsp_code_point, rsp_seq_length, rsp_stray_continuation);
      end
   end

   // Receiver: drive rsp_ready at the falling edge. Drop it for random bursts
   // while idling is on, and once for a long stretch when pressure is asked.
   int unsigned hold_left = 0;
   logic        pressure_done = 1'b0;

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_go && !pressure_done) begin
         rsp_ready     <= 1'b0;
         hold_left     <= 299;
         pressure_done <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one byte and hold it until the transaction completes. Called and
   // returns at a falling edge; may leave a random gap after the byte.
   int unsigned bytes_sent = 0;

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      bytes_sent++;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid     <= 1'b0;
         req_data_byte <= BYTE_W'($urandom);
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   function automatic logic [BYTE_W-1:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // Send one random unit: mostly well-formed characters with random
   // payload, some stray continuations and 0xFC..0xFF leads, and a few
   // broken sequences whose tail bytes are arbitrary.
   task automatic send_unit();
      int unsigned kind;
      int unsigned len;
      logic [BYTE_W-1:0] lead;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         send_byte({1'b0, 7'($urandom)});
      end else if (kind < 40) begin
         send_byte(cont_byte());
      end else if (kind < 45) begin
         send_byte({6'b111111, 2'($urandom)});
      end else begin
         len = $urandom_range(2, 5);
         case (len)
            2: begin
               lead = {3'b110, 5'($urandom)};
            end
            3: begin
               lead = {4'b1110, 4'($urandom)};
            end
            4: begin
               lead = {5'b11110, 3'($urandom)};
            end
            default: begin
               lead = {6'b111110, 2'($urandom)};
            end
         endcase
         send_byte(lead);
         for (int i = 1; i < len; i++) begin
            if (kind >= 92)
               send_byte(BYTE_W'($urandom));
            else
               send_byte(cont_byte());
         end
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] directed[$];
      directed = '{
         8'h00, 8'h7F,                      // ASCII extremes
         8'h80, 8'hBF,                      // stray continuation bytes
         8'hDF, 8'hBF,                      // largest 2-byte character
         8'hEF, 8'hBF, 8'hBF,               // largest 3-byte character
         8'hF7, 8'hBF, 8'hBF, 8'hBF,        // largest 4-byte character
         8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, // largest 5-byte character
         8'hFC, 8'hFF,                      // leads with no matching prefix
         8'hE0, 8'hFF, 8'h41                // lead, then 0xFF and ASCII as payload
      };
      sb = new();

      // Hold reset, then release it at a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes first, with no idling.
      foreach (directed[i])
         send_byte(directed[i]);

      // Random stream with idling on both sides.
      idle_on <= 1'b1;
      while (bytes_sent < 600)
         send_unit();

      // Hold the receiver off and keep offering ASCII back to back so the
      // decoder fills up and stalls its input.
      idle_on     <= 1'b0;
      pressure_go <= 1'b1;
      repeat (60)
         send_byte({1'b0, 7'($urandom)});

      idle_on <= 1'b1;
      while (bytes_sent < 950)
         send_unit();

      // Last stretch: no idling at all.
      idle_on <= 1'b0;
      while (bytes_sent < 1250)
         send_unit();
      req_valid <= 1'b0;

      // Drain: wait for every expected character, then let the pipeline
      // settle so a stray extra result would still show up.
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
